### rtl/ansplit_pkg.sv
// Shared types and constants of the Annex B NAL unit splitter.
package ansplit_pkg;

	localparam int LenW  = 24;
	localparam int CntW  = 8;
	localparam int PayN  = 4;
	localparam int SlotN = PayN + 1;

	localparam logic [LenW-1:0] LEN_MAX = {LenW{1'b1}};

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	localparam logic CFG_MAX_BYTES = 1'b0;
	localparam logic CFG_MAX_COUNT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_TOO_MANY = 2'd2
	} nalu_status_t;

	// start code mode of the current access unit
	typedef enum logic [3:0] {
		MODE_UNDEC = 4'b0001,
		MODE_SC3   = 4'b0010,
		MODE_SC4   = 4'b0100,
		MODE_RAW   = 4'b1000
	} mode_t;

	// all words caused by one input byte: up to four payload slots and an end record slot
	typedef struct packed {
		logic [SlotN-1:0]         mask;
		logic [PayN-1:0][7:0]     pay;
		logic [CntW-1:0]          index;
		logic [LenW-1:0]          bytes;
		nalu_status_t             status;
		logic                     uend;
	} res_batch_t;

endpackage

### rtl/ansplit_core.sv
// Start code detection, window handling and NAL unit accounting for one input byte.
module ansplit_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [7:0]                    in_byte,
	input  logic                          unit_last,
	input  logic [ansplit_pkg::LenW-1:0]  max_bytes,
	input  logic [ansplit_pkg::CntW-1:0]  max_count,
	output ansplit_pkg::res_batch_t       batch
);
	import ansplit_pkg::*;

	logic [23:0]     win_q;
	logic [1:0]      fill_q;
	mode_t           mode_q;
	logic [1:0]      pos_q;
	logic [LenW-1:0] len_q;
	logic [CntW:0]   cnt_q;
	logic            inside_q;

	logic [23:0]          w;
	logic [1:0]           f;
	mode_t                md;
	logic [1:0]           ps;
	logic [2:0]           np;
	logic [PayN-1:0][7:0] pl;
	logic                 close_req;
	logic                 ended;
	logic                 cnt_ok;
	logic [LenW-1:0]      len_r;
	logic [LenW-1:0]      len_n;
	logic [CntW:0]        cnt_n;
	logic                 inside_n;
	logic [SlotN-1:0]     mask;
	logic [LenW-1:0]      rec_bytes;
	nalu_status_t         rec_status;

	function automatic logic [7:0] win_byte(logic [23:0] wv, logic [1:0] i);
		logic [7:0] r;
		case (i)
			2'd0:    r = wv[7:0];
			2'd1:    r = wv[15:8];
			default: r = wv[23:16];
		endcase
		return r;
	endfunction

	always_comb begin
		w         = win_q;
		f         = fill_q;
		md        = mode_q;
		ps        = pos_q;
		np        = '0;
		pl        = '0;
		close_req = 1'b0;
		ended     = 1'b0;

		case (mode_q)
			MODE_UNDEC: begin
				if (in_byte == 8'd1 && pos_q == 2'd2) begin
					md = MODE_SC3;
					w  = '0;
					f  = '0;
				end else if (in_byte == 8'd1 && pos_q == 2'd3) begin
					md = MODE_SC4;
					w  = '0;
					f  = '0;
				end else if (in_byte == 8'd0 && pos_q != 2'd3) begin
					w  = {win_q[15:0], 8'h00};
					f  = fill_q + 2'd1;
					ps = pos_q + 2'd1;
				end else begin
					// no start code prefix: held zeros and this byte are payload
					md = MODE_RAW;
					for (int k = 0; k < 3; k++) begin
						if (2'(k) < fill_q)
							pl[k] = win_byte(win_q, fill_q - 2'd1 - 2'(k));
					end
					pl[fill_q] = in_byte;
					np = {1'b0, fill_q} + 3'd1;
					w  = '0;
					f  = '0;
				end
			end
			MODE_RAW: begin
				pl[0] = in_byte;
				np    = 3'd1;
			end
			MODE_SC3, MODE_SC4: begin
				if (fill_q == ((mode_q == MODE_SC3) ? 2'd2 : 2'd3) && in_byte == 8'd1 &&
				    ((mode_q == MODE_SC3) ? (win_q[15:0] == '0) : (win_q == '0))) begin
					w         = '0;
					f         = '0;
					close_req = 1'b1;
					ended     = unit_last;
				end else if (fill_q >= ((mode_q == MODE_SC3) ? 2'd2 : 2'd3)) begin
					// window full: oldest byte leaves as payload
					pl[0] = (mode_q == MODE_SC3) ? win_q[15:8] : win_q[23:16];
					np    = 3'd1;
					w     = (mode_q == MODE_SC3) ? {8'h00, win_q[7:0], in_byte}
					                             : {win_q[15:0], in_byte};
					f     = (mode_q == MODE_SC3) ? 2'd2 : 2'd3;
				end else begin
					w = {win_q[15:0], in_byte};
					f = fill_q + 2'd1;
				end
			end
			default: begin
				md = mode_q;
			end
		endcase

		// end of access unit: drain the window and close the open unit
		if (unit_last && !ended) begin
			for (int k = 0; k < 3; k++) begin
				if (2'(k) < f)
					pl[2'(np + 3'(k))] = win_byte(w, f - 2'd1 - 2'(k));
			end
			np        = np + {1'b0, f};
			close_req = 1'b1;
		end

		cnt_ok = cnt_q < {1'b0, max_count};
		len_r  = len_q;
		mask   = '0;
		for (int i = 0; i < PayN; i++) begin
			if (3'(i) < np) begin
				mask[i] = cnt_ok && (len_r < max_bytes);
				if (len_r != LEN_MAX)
					len_r = len_r + 1'b1;
			end
		end

		len_n      = len_r;
		cnt_n      = cnt_q;
		inside_n   = inside_q || (np != 3'd0);
		rec_bytes  = '0;
		rec_status = ST_OK;
		if (close_req) begin
			if (inside_n) begin
				mask[PayN] = 1'b1;
				rec_bytes  = len_r;
				if (!cnt_ok)
					rec_status = ST_TOO_MANY;
				else if (len_r > max_bytes)
					rec_status = ST_TOO_LONG;
				cnt_n    = cnt_q[CntW] ? cnt_q : cnt_q + 1'b1;
				len_n    = '0;
				inside_n = 1'b0;
			end else if (unit_last) begin
				mask[PayN] = 1'b1;
			end
		end

		batch.mask   = mask;
		batch.pay    = pl;
		batch.index  = cnt_q[CntW] ? {CntW{1'b1}} : cnt_q[CntW-1:0];
		batch.bytes  = rec_bytes;
		batch.status = rec_status;
		batch.uend   = unit_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= '0;
			fill_q   <= '0;
			mode_q   <= MODE_UNDEC;
			pos_q    <= '0;
			len_q    <= '0;
			cnt_q    <= '0;
			inside_q <= 1'b0;
		end else if (accept) begin
			if (unit_last) begin
				win_q    <= '0;
				fill_q   <= '0;
				mode_q   <= MODE_UNDEC;
				pos_q    <= '0;
				len_q    <= '0;
				cnt_q    <= '0;
				inside_q <= 1'b0;
			end else begin
				win_q    <= w;
				fill_q   <= f;
				mode_q   <= md;
				pos_q    <= ps;
				len_q    <= len_n;
				cnt_q    <= cnt_n;
				inside_q <= inside_n;
			end
		end
	end

endmodule

### rtl/ansplit_serializer.sv
// Holds the words of one input byte and hands them out one per cycle while m_tready is high.
module ansplit_serializer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  ansplit_pkg::res_batch_t       batch_in,
	output logic                          can_load,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic                          m_tlast,
	output logic                          kind,
	output logic [7:0]                    data_byte,
	output logic [ansplit_pkg::CntW-1:0]  nalu_index,
	output logic [ansplit_pkg::LenW-1:0]  nalu_bytes,
	output logic [1:0]                    nalu_status,
	output logic                          unit_end
);
	import ansplit_pkg::*;

	logic [SlotN-1:0] mask_q;
	res_batch_t       batch_q;
	logic [SlotN-1:0] head;
	logic             single;
	logic [7:0]       pay_sel;

	assign head   = mask_q & (~mask_q + 1'b1);
	assign single = (mask_q & (mask_q - 1'b1)) == '0;

	always_comb begin
		pay_sel = '0;
		for (int i = PayN - 1; i >= 0; i--) begin
			if (mask_q[i])
				pay_sel = batch_q.pay[i];
		end
	end

	assign m_tvalid    = |mask_q;
	assign m_tlast     = single;
	assign can_load    = single && (m_tready || mask_q == '0);
	assign kind        = head[PayN] ? KIND_END : KIND_PAYLOAD;
	assign data_byte   = head[PayN] ? 8'h00 : pay_sel;
	assign nalu_index  = batch_q.index;
	assign nalu_bytes  = head[PayN] ? batch_q.bytes : '0;
	assign nalu_status = head[PayN] ? batch_q.status : ST_OK;
	assign unit_end    = head[PayN] & batch_q.uend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mask_q <= '0;
		else if (load)
			mask_q <= batch_in.mask;
		else if (m_tvalid && m_tready)
			mask_q <= mask_q & ~head;
	end

	always_ff @(posedge clk) begin
		if (load)
			batch_q <= batch_in;
	end

endmodule

### rtl/annexb_nal_unit_splitter_unit.sv
// Top level of the Annex B NAL unit splitter: config registers, core and word serializer.
// The serializer registers the words of each input byte; the first one appears on the master
// side in the cycle after the byte is taken. Throughput: one byte per cycle while each byte
// yields at most one word and m_tready is high; a byte that yields more than one word (held
// zeros, window drain, end record) holds s_tready low until only its final word is left.
// Reset: arst_n clears the splitter state and output queue; limits return to 65536 and 16.
module annexb_nal_unit_splitter_unit (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // unit_last
	// output words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] data_byte, [15:8] nalu_index, [39:16] nalu_bytes,
	                               // [41:40] nalu_status, [42] unit_end, [47:43] zero
	output logic        m_tuser,   // kind
	output logic        m_tlast,   // run_last
	// configuration writes
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_data
);
	import ansplit_pkg::*;

	logic [LenW-1:0] max_bytes_q;
	logic [CntW-1:0] max_count_q;
	logic            accept;
	res_batch_t      batch;
	logic [7:0]      data_byte;
	logic [CntW-1:0] nalu_index;
	logic [LenW-1:0] nalu_bytes;
	logic [1:0]      nalu_status;
	logic            unit_end;

	// limits; the user must write them only while the splitter is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_bytes_q <= LenW'(65536);
			max_count_q <= CntW'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_BYTES: max_bytes_q <= cfg_data;
				CFG_MAX_COUNT: max_count_q <= cfg_data[CntW-1:0];
				default:       max_count_q <= max_count_q;
			endcase
		end
	end

	// a byte is taken only when the queue is empty or drains its final word now
	assign accept = s_tvalid && s_tready;

	ansplit_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (s_tdata),
		.unit_last (s_tlast),
		.max_bytes (max_bytes_q),
		.max_count (max_count_q),
		.batch     (batch)
	);

	ansplit_serializer u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept),
		.batch_in    (batch),
		.can_load    (s_tready),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tlast     (m_tlast),
		.kind        (m_tuser),
		.data_byte   (data_byte),
		.nalu_index  (nalu_index),
		.nalu_bytes  (nalu_bytes),
		.nalu_status (nalu_status),
		.unit_end    (unit_end)
	);

	assign m_tdata = {5'b00000, unit_end, nalu_status, nalu_bytes, nalu_index, data_byte};

endmodule
